### design/bdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded double-ended queue
// Sizes, command codes and the control word that runs the row of cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int Depth        = 16;
   localparam int DataWidth    = 32;
   localparam int CountWidth   = $clog2(Depth + 1);
   localparam int CommandWidth = 2;
   localparam int CapWidth     = 5;
   localparam int EntryWidth   = 5;

   typedef enum logic [CommandWidth-1:0] {
      CMD_INSERT_FRONT = 2'd0,
      CMD_INSERT_REAR  = 2'd1,
      CMD_REMOVE_FRONT = 2'd2,
      CMD_REMOVE_REAR  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT_BACK,
      OP_SHIFT_FORWARD,
      OP_APPEND,
      OP_TRIM
   } cell_op_type;

   typedef struct packed {
      cell_op_type                 op;
      logic signed [DataWidth-1:0] word;
   } cell_ctrl_type;

endpackage

### design/bdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell: one position of the queue
// Holds one word and an occupied bit, and trades them with its neighbors.
// ----------------------------------------------------------------------------
module bdq_cell
   import bdq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cell_ctrl_type               ctrl,
   input  logic signed [DataWidth-1:0] left_data,
   input  logic                        left_occ,
   input  logic signed [DataWidth-1:0] right_data,
   input  logic                        right_occ,
   input  logic signed [DataWidth-1:0] rear_acc_in,
   output logic signed [DataWidth-1:0] rear_acc_out,
   output logic signed [DataWidth-1:0] data,
   output logic                        occ
);

   logic signed [DataWidth-1:0] data_ff;
   logic signed [DataWidth-1:0] data_in;
   logic                        occ_ff;
   logic                        occ_in;
   logic                        is_rear;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      unique case (ctrl.op)
         OP_SHIFT_BACK: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         OP_SHIFT_FORWARD: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         OP_APPEND: begin
            if (!occ_ff && left_occ) begin
               data_in = ctrl.word;
            end
            occ_in = left_occ;
         end
         OP_TRIM: begin
            occ_in = right_occ;
         end
         default: begin
            data_in = data_ff;
            occ_in  = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign is_rear      = occ_ff && !right_occ;
   assign rear_acc_out = rear_acc_in | (data_ff & {DataWidth{is_rear}});
   assign data         = data_ff;
   assign occ          = occ_ff;

endmodule

### design/bounded_double_ended_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core: bounded deque of signed 32-bit words
// A row of cells holds the entries with the front in the first cell.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and busy stays low. The
// result of an item appears on the rsp_ ports, marked by rsp_strobe, in the
// cycle right after the item was taken; the whole row of cells shifts or
// loads together, so back-to-back items give back-to-back
// results. The receiver cannot stall, so each result must be captured in
// its strobe cycle. The capacity register is clamped to the queue depth and
// should be written only while no item is in flight.
module bounded_double_ended_queue_core
   import bdq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [CommandWidth-1:0]      req_command,
   input  logic signed [DataWidth-1:0]  req_data_word,
   output logic                         rsp_strobe,
   output logic                         rsp_accepted,
   output logic signed [DataWidth-1:0]  rsp_front_value,
   output logic                         rsp_front_valid,
   output logic signed [DataWidth-1:0]  rsp_rear_value,
   output logic                         rsp_queue_empty,
   output logic                         rsp_queue_full,
   output logic [EntryWidth-1:0]        rsp_entry_count,
   input  logic                         csr_write_enable,
   input  logic [CapWidth-1:0]          csr_write_data
);

   logic [CapWidth-1:0]         capacity_ff;
   logic [CountWidth-1:0]       count_ff;
   logic [CountWidth-1:0]       count_in;
   logic                        strobe_ff;
   logic                        accepted_ff;
   logic [CountWidth-1:0]       cap_eff;
   logic                        full;
   logic                        empty;
   logic                        ok;
   cell_ctrl_type               ctrl;
   logic signed [DataWidth-1:0] cell_data [Depth];
   logic                        cell_occ  [Depth];
   logic signed [DataWidth-1:0] rear_acc  [Depth+1];

   always_comb begin
      if (int'(capacity_ff) > Depth) begin
         cap_eff = CountWidth'(Depth);
      end else begin
         cap_eff = CountWidth'(capacity_ff);
      end
   end

   assign full  = count_ff >= cap_eff;
   assign empty = count_ff == '0;

   always_comb begin
      ok        = 1'b0;
      ctrl.op   = OP_HOLD;
      ctrl.word = req_data_word;
      count_in  = count_ff;
      unique case (command_type'(req_command))
         CMD_INSERT_FRONT: begin
            ok = !full;
            if (start && ok) begin
               ctrl.op  = OP_SHIFT_BACK;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_INSERT_REAR: begin
            ok = !full;
            if (start && ok) begin
               ctrl.op  = OP_APPEND;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_REMOVE_FRONT: begin
            ok = !empty;
            if (start && ok) begin
               ctrl.op  = OP_SHIFT_FORWARD;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_REMOVE_REAR: begin
            ok = !empty;
            if (start && ok) begin
               ctrl.op  = OP_TRIM;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapWidth'(Depth);
         count_ff    <= '0;
         strobe_ff   <= 1'b0;
         accepted_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         count_ff    <= count_in;
         strobe_ff   <= start;
         accepted_ff <= start && ok;
      end
   end

   assign rear_acc[0] = '0;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic signed [DataWidth-1:0] left_data;
      logic                        left_occ;
      logic signed [DataWidth-1:0] right_data;
      logic                        right_occ;

      if (i == 0) begin : g_first
         assign left_data = req_data_word;
         assign left_occ  = 1'b1;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      bdq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .left_data    (left_data),
         .left_occ     (left_occ),
         .right_data   (right_data),
         .right_occ    (right_occ),
         .rear_acc_in  (rear_acc[i]),
         .rear_acc_out (rear_acc[i+1]),
         .data         (cell_data[i]),
         .occ          (cell_occ[i])
      );
   end

   assign busy            = 1'b0;
   assign rsp_strobe      = strobe_ff;
   assign rsp_accepted    = accepted_ff;
   assign rsp_front_value = cell_data[0] & {DataWidth{cell_occ[0]}};
   assign rsp_front_valid = !empty;
   assign rsp_rear_value  = rear_acc[Depth];
   assign rsp_queue_empty = empty;
   assign rsp_queue_full  = full;
   assign rsp_entry_count = EntryWidth'(count_ff);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the bounded double-ended queue core
// Drives insert and remove commands at both ends under several capacity
// settings and sender gap patterns. A ring-buffer model of the deque runs
// beside the core and checks every reported front, rear, flag and count.
// ----------------------------------------------------------------------------
module testbench;
   import bdq_pkg::*;

   localparam int StallLimit = 2000;
   localparam int MaxGap     = 40;

   typedef struct packed {
      logic                        accepted;
      logic signed [DataWidth-1:0] front_value;
      logic                        front_valid;
      logic signed [DataWidth-1:0] rear_value;
      logic                        queue_empty;
      logic                        queue_full;
      logic [EntryWidth-1:0]       entry_count;
   } deque_view_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [CommandWidth-1:0]     req_command = '0;
   logic signed [DataWidth-1:0] req_data_word = '0;
   logic                        rsp_strobe;
   logic                        rsp_accepted;
   logic signed [DataWidth-1:0] rsp_front_value;
   logic                        rsp_front_valid;
   logic signed [DataWidth-1:0] rsp_rear_value;
   logic                        rsp_queue_empty;
   logic                        rsp_queue_full;
   logic [EntryWidth-1:0]       rsp_entry_count;
   logic                        csr_write_enable = 1'b0;
   logic [CapWidth-1:0]         csr_write_data = '0;

   logic signed [DataWidth-1:0] ring_words [Depth];
   int                          ring_head;
   int                          ring_count;
   logic [CapWidth-1:0]         capacity_setting;
   deque_view_type              pending_views [$];
   int                          mismatch_count = 0;
   int                          stall_cycles = 0;
   int                          sender_idle_pct = 0;

   bounded_double_ended_queue_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_data_word    (req_data_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_accepted     (rsp_accepted),
      .rsp_front_value  (rsp_front_value),
      .rsp_front_valid  (rsp_front_valid),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_queue_empty  (rsp_queue_empty),
      .rsp_queue_full   (rsp_queue_full),
      .rsp_entry_count  (rsp_entry_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void check_field(string field, logic [DataWidth-1:0] want,
                                       logic [DataWidth-1:0] got);
      if (got !== want) begin
         note_mismatch($sformatf("%s expected %0h, got %0h", field, want, got));
      end
   endfunction

   function automatic void apply_command(command_type cmd, logic signed [DataWidth-1:0] word);
      int             limit;
      bit             was_full;
      bit             was_empty;
      deque_view_type view;
      limit = (capacity_setting > Depth) ? Depth : int'(capacity_setting);
      was_full = ring_count >= limit;
      was_empty = ring_count == 0;
      view = '0;
      case (cmd)
         CMD_INSERT_FRONT: begin
            if (!was_full) begin
               ring_head = (ring_head + Depth - 1) % Depth;
               ring_words[ring_head] = word;
               ring_count++;
               view.accepted = 1'b1;
            end
         end
         CMD_INSERT_REAR: begin
            if (!was_full) begin
               ring_words[(ring_head + ring_count) % Depth] = word;
               ring_count++;
               view.accepted = 1'b1;
            end
         end
         CMD_REMOVE_FRONT: begin
            if (!was_empty) begin
               ring_head = (ring_head + 1) % Depth;
               ring_count--;
               view.accepted = 1'b1;
            end
         end
         default: begin
            if (!was_empty) begin
               ring_count--;
               view.accepted = 1'b1;
            end
         end
      endcase
      view.entry_count = EntryWidth'(ring_count);
      view.queue_empty = ring_count == 0;
      view.queue_full = ring_count >= limit;
      if (ring_count != 0) begin
         view.front_valid = 1'b1;
         view.front_value = ring_words[ring_head];
         view.rear_value = ring_words[(ring_head + ring_count - 1) % Depth];
      end
      pending_views.push_back(view);
   endfunction

   always @(posedge clock) begin : monitor
      bit             progress;
      deque_view_type want;
      if (reset) begin
         ring_head = 0;
         ring_count = 0;
         capacity_setting = CapWidth'(16);
         pending_views.delete();
         stall_cycles = 0;
      end else begin
         progress = 1'b0;
         if (start && !busy) begin
            apply_command(command_type'(req_command), req_data_word);
            progress = 1'b1;
         end
         if (rsp_strobe) begin
            progress = 1'b1;
            if (pending_views.size() == 0) begin
               note_mismatch("result arrived with no item outstanding");
            end else begin
               want = pending_views.pop_front();
               check_field("accepted", DataWidth'(want.accepted),
                           DataWidth'(rsp_accepted));
               check_field("front_value", want.front_value, rsp_front_value);
               check_field("front_valid", DataWidth'(want.front_valid),
                           DataWidth'(rsp_front_valid));
               check_field("rear_value", want.rear_value, rsp_rear_value);
               check_field("queue_empty", DataWidth'(want.queue_empty),
                           DataWidth'(rsp_queue_empty));
               check_field("queue_full", DataWidth'(want.queue_full),
                           DataWidth'(rsp_queue_full));
               check_field("entry_count", DataWidth'(want.entry_count),
                           DataWidth'(rsp_entry_count));
            end
         end
         if (csr_write_enable) begin
            capacity_setting = csr_write_data;
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      while (stall_cycles < StallLimit) begin
         @(posedge clock);
      end
      $display("bounded_double_ended_queue_core: mismatch");
      $finish;
   end

   task automatic send_item(command_type cmd, logic signed [DataWidth-1:0] word);
      int gap;
      start <= 1'b1;
      req_command <= cmd;
      req_data_word <= word;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      gap = 0;
      while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_items();
      start <= 1'b0;
      while (pending_views.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(int value);
      drain_items();
      csr_write_enable <= 1'b1;
      csr_write_data <= CapWidth'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_empty_removes();
      sender_idle_pct = 0;
      send_item(CMD_REMOVE_FRONT, 32'sh1234_5678);
      send_item(CMD_REMOVE_REAR, -32'sd1);
   endtask

   task automatic test_extreme_words();
      set_capacity(16);
      send_item(CMD_INSERT_FRONT, 32'sh8000_0000);
      send_item(CMD_INSERT_REAR, 32'sh7FFF_FFFF);
      send_item(CMD_INSERT_FRONT, 32'sd0);
      send_item(CMD_INSERT_REAR, -32'sd1);
      send_item(CMD_REMOVE_REAR, 32'sd0);
      send_item(CMD_REMOVE_FRONT, 32'sd0);
   endtask

   task automatic test_capacity_edges();
      // The queue holds two entries here; a limit of three fills it in one.
      set_capacity(3);
      send_item(CMD_INSERT_REAR, 32'sh5555_5555);
      send_item(CMD_INSERT_FRONT, 32'shAAAA_AAAA);
      // A limit below the count reports full, yet removes still work.
      set_capacity(2);
      send_item(CMD_INSERT_REAR, 32'sh0F0F_0F0F);
      send_item(CMD_REMOVE_FRONT, 32'sd0);
      send_item(CMD_REMOVE_REAR, 32'sd0);
      send_item(CMD_REMOVE_REAR, 32'sd0);
      send_item(CMD_REMOVE_FRONT, 32'sd0);
      set_capacity(0);
      send_item(CMD_INSERT_FRONT, 32'sh0000_0001);
      send_item(CMD_INSERT_REAR, 32'shFFFF_FFFE);
   endtask

   task automatic test_random_traffic(int items, int capacity, int idle_pct);
      int                          n;
      bit                          filling;
      command_type                 cmd;
      logic signed [DataWidth-1:0] word;
      set_capacity(capacity);
      sender_idle_pct = idle_pct;
      filling = 1'b1;
      for (n = 0; n < items; n++) begin
         if (n % 24 == 23) begin
            filling = !filling;
         end
         if (($urandom_range(99) < 75) == filling) begin
            cmd = command_type'($urandom_range(1));
         end else begin
            cmd = command_type'(2 + $urandom_range(1));
         end
         case ($urandom_range(7))
            0: word = 32'sh8000_0000;
            1: word = 32'sh7FFF_FFFF;
            default: word = $urandom;
         endcase
         send_item(cmd, word);
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_removes();
      test_extreme_words();
      test_capacity_edges();
      test_random_traffic(150, 16, 0);
      test_random_traffic(120, 31, 84);
      test_random_traffic(120, 5, 15);
      test_random_traffic(60, 1, 0);
      test_random_traffic(20, 0, 15);
      test_random_traffic(80, 17, 15);
      drain_items();
      if (mismatch_count == 0 && pending_views.size() == 0) begin
         $display("bounded_double_ended_queue_core: match");
      end else begin
         $display("bounded_double_ended_queue_core: mismatch");
      end
      $finish;
   end

endmodule
